// File: design/pxa_pkg.sv
// ----------------------------------------------------------------------------
// pxa_pkg: shared types and constants of the execute ALU stage
// Opcodes, handoff codes, packed transaction layouts and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pxa_pkg;

   localparam int unsigned XLEN     = 32;
   localparam int unsigned CNT_W    = $clog2(XLEN);
   localparam int unsigned REQ_W    = 184;
   localparam int unsigned RSP_W    = 112;

   // opcodes
   localparam logic [5:0] OP_ADD  = 6'd0;
   localparam logic [5:0] OP_SUB  = 6'd1;
   localparam logic [5:0] OP_MUL  = 6'd2;
   localparam logic [5:0] OP_DIV  = 6'd3;
   localparam logic [5:0] OP_SLL  = 6'd4;
   localparam logic [5:0] OP_SLLV = 6'd5;
   localparam logic [5:0] OP_SRL  = 6'd6;
   localparam logic [5:0] OP_SRLV = 6'd7;
   localparam logic [5:0] OP_SRA  = 6'd8;
   localparam logic [5:0] OP_SRAV = 6'd9;
   localparam logic [5:0] OP_AND  = 6'd10;
   localparam logic [5:0] OP_OR   = 6'd11;
   localparam logic [5:0] OP_XOR  = 6'd12;
   localparam logic [5:0] OP_NOR  = 6'd13;
   localparam logic [5:0] OP_ADDI = 6'd23;
   localparam logic [5:0] OP_SUBI = 6'd24;
   localparam logic [5:0] OP_MULI = 6'd25;
   localparam logic [5:0] OP_DIVI = 6'd26;
   localparam logic [5:0] OP_SLTI = 6'd27;
   localparam logic [5:0] OP_ANDI = 6'd28;
   localparam logic [5:0] OP_ORI  = 6'd29;
   localparam logic [5:0] OP_XORI = 6'd30;
   localparam logic [5:0] OP_SW   = 6'd31;
   localparam logic [5:0] OP_LW   = 6'd32;
   localparam logic [5:0] OP_LI   = 6'd33;
   localparam logic [5:0] OP_B    = 6'd34;
   localparam logic [5:0] OP_BEQ  = 6'd35;
   localparam logic [5:0] OP_BNE  = 6'd36;
   localparam logic [5:0] OP_BGT  = 6'd39;
   localparam logic [5:0] OP_BLT  = 6'd40;
   localparam logic [5:0] OP_J    = 6'd47;

   // what the stage handed on to memory
   localparam logic [1:0] HANDOFF_NONE   = 2'd0;
   localparam logic [1:0] HANDOFF_BUBBLE = 2'd1;
   localparam logic [1:0] HANDOFF_RESULT = 2'd2;

   // request tdata, last field (op_code) in the lowest bits
   typedef struct packed {
      logic [6:0]  pad;
      logic        memory_blocked;
      logic [31:0] jump_target;
      logic [31:0] store_or_compare;
      logic [31:0] immediate;
      logic [4:0]  shift_amount;
      logic [31:0] operand_b;
      logic [31:0] operand_a;
      logic [4:0]  dest_register;
      logic [5:0]  op_code;
   } req_data_type;

   // response tdata, last field (out_op_code) in the lowest bits
   typedef struct packed {
      logic [2:0]  pad;
      logic        stage_blocked;
      logic [31:0] target_address;
      logic        taken_flag;
      logic [31:0] store_data;
      logic [31:0] result_value;
      logic [4:0]  out_dest_register;
      logic [5:0]  out_op_code;
   } rsp_data_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

// File: design/pxa_divider.sv
// ----------------------------------------------------------------------------
// pxa_divider: unsigned restoring divider, one quotient bit a cycle while step is high
// Works on operand magnitudes; signs and special cases are handled outside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pxa_divider (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire                        step,
   input  wire [pxa_pkg::XLEN-1:0]    dividend,
   input  wire [pxa_pkg::XLEN-1:0]    divisor,
   output logic [pxa_pkg::XLEN-1:0]   quotient,
   output logic                       last
);

   logic [pxa_pkg::XLEN-1:0]  rem_ff, rem_in;
   logic [pxa_pkg::XLEN-1:0]  quot_ff, quot_in;
   logic [pxa_pkg::XLEN-1:0]  dsr_ff, dsr_in;
   logic [pxa_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [pxa_pkg::XLEN:0]    shifted;
   logic [pxa_pkg::XLEN:0]    diff;

   // one trial subtraction per step
   always_comb begin
      shifted = {rem_ff, quot_ff[pxa_pkg::XLEN-1]};
      diff    = shifted - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         rem_in  = '0;
         quot_in = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
      end else if (step) begin
         if (diff[pxa_pkg::XLEN]) begin
            rem_in = shifted[pxa_pkg::XLEN-1:0];
         end else begin
            rem_in = diff[pxa_pkg::XLEN-1:0];
         end
         quot_in = {quot_ff[pxa_pkg::XLEN-2:0], ~diff[pxa_pkg::XLEN]};
         cnt_in  = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign quotient = quot_ff;
   assign last     = (cnt_ff == {pxa_pkg::CNT_W{1'b1}});

endmodule

`default_nettype wire

// File: design/pxa_datapath.sv
// ----------------------------------------------------------------------------
// pxa_datapath: operand latch, ALU, divider and held result registers
// Executes the latched instruction on commit and presents the held state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pxa_datapath (
   input  wire                         clock,
   input  wire                         reset,
   input  wire pxa_pkg::cmd_type       cmd,
   output pxa_pkg::status_type         status,
   input  wire [pxa_pkg::REQ_W-1:0]    req_tdata,
   input  wire                         req_tuser,
   output logic [pxa_pkg::RSP_W-1:0]   rsp_tdata,
   output logic [1:0]                  rsp_tuser
);

   pxa_pkg::req_data_type in_ff;
   logic                  has_ff;

   logic [5:0]  op_ff, op_in;
   logic [4:0]  dest_ff, dest_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] store_ff, store_in;
   logic        taken_ff, taken_in;
   logic [31:0] target_ff, target_in;
   logic        stalled_ff, stalled_in;
   logic [1:0]  handoff_ff, handoff_in;

   logic [31:0] opa, opb, imm, cmp;
   logic [4:0]  sh, shv;
   logic [31:0] mul_src, mul_lo;
   logic [31:0] div_raw, dvd_mag, dsr_mag, div_q, div_res;
   logic        div_op, div_last;
   pxa_pkg::rsp_data_type rsp;

   assign opa = in_ff.operand_a;
   assign opb = in_ff.operand_b;
   assign imm = in_ff.immediate;
   assign cmp = in_ff.store_or_compare;
   assign sh  = in_ff.shift_amount;
   assign shv = opb[4:0];

   // latch the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff  <= pxa_pkg::req_data_type'(req_tdata);
         has_ff <= req_tuser;
      end
   end

   // divide operands as magnitudes
   assign div_op  = (in_ff.op_code == pxa_pkg::OP_DIV) || (in_ff.op_code == pxa_pkg::OP_DIVI);
   assign div_raw = (in_ff.op_code == pxa_pkg::OP_DIV) ? opb : imm;
   assign dvd_mag = opa[31] ? (32'd0 - opa) : opa;
   assign dsr_mag = div_raw[31] ? (32'd0 - div_raw) : div_raw;

   pxa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (dvd_mag),
      .divisor  (dsr_mag),
      .quotient (div_q),
      .last     (div_last)
   );

   // zero divisor gives all ones; sign restored on the quotient
   always_comb begin
      if (div_raw == 32'd0) begin
         div_res = 32'hFFFF_FFFF;
      end else if (opa[31] ^ div_raw[31]) begin
         div_res = 32'd0 - div_q;
      end else begin
         div_res = div_q;
      end
   end

   assign mul_src = (in_ff.op_code == pxa_pkg::OP_MUL) ? opb : imm;
   assign mul_lo  = opa * mul_src;

   assign status.need_div = has_ff && !stalled_ff && div_op;
   assign status.div_last = div_last;

   // execute and update the held result
   always_comb begin
      op_in      = op_ff;
      dest_in    = dest_ff;
      value_in   = value_ff;
      store_in   = store_ff;
      taken_in   = taken_ff;
      target_in  = target_ff;
      stalled_in = stalled_ff;
      handoff_in = handoff_ff;
      if (cmd.commit) begin
         if (has_ff) begin
            if (!stalled_ff) begin
               op_in   = in_ff.op_code;
               dest_in = in_ff.dest_register;
               case (in_ff.op_code)
                  pxa_pkg::OP_ADD:  value_in = opa + opb;
                  pxa_pkg::OP_SUB:  value_in = opa - opb;
                  pxa_pkg::OP_MUL:  value_in = mul_lo;
                  pxa_pkg::OP_DIV:  value_in = div_res;
                  pxa_pkg::OP_SLL:  value_in = opa << sh;
                  pxa_pkg::OP_SLLV: value_in = opa << shv;
                  pxa_pkg::OP_SRL:  value_in = opa >> sh;
                  pxa_pkg::OP_SRLV: value_in = opa >> shv;
                  pxa_pkg::OP_SRA:  value_in = 32'($signed(opa) >>> sh);
                  pxa_pkg::OP_SRAV: value_in = 32'($signed(opa) >>> shv);
                  pxa_pkg::OP_AND:  value_in = opa & opb;
                  pxa_pkg::OP_OR:   value_in = opa | opb;
                  pxa_pkg::OP_XOR:  value_in = opa ^ opb;
                  pxa_pkg::OP_NOR:  value_in = ~(opa | opb);
                  pxa_pkg::OP_ADDI: value_in = opa + imm;
                  pxa_pkg::OP_SUBI: value_in = opa - imm;
                  pxa_pkg::OP_MULI: value_in = mul_lo;
                  pxa_pkg::OP_DIVI: value_in = div_res;
                  pxa_pkg::OP_SLTI: value_in = {31'd0, $signed(opa) < $signed(imm)};
                  pxa_pkg::OP_ANDI: value_in = opa & imm;
                  pxa_pkg::OP_ORI:  value_in = opa | imm;
                  pxa_pkg::OP_XORI: value_in = opa ^ imm;
                  pxa_pkg::OP_SW: begin
                     value_in = opa + imm;
                     store_in = cmp;
                  end
                  pxa_pkg::OP_LW:   value_in = opa + imm;
                  pxa_pkg::OP_LI:   value_in = imm;
                  pxa_pkg::OP_B: begin
                     taken_in  = 1'b1;
                     target_in = imm;
                  end
                  pxa_pkg::OP_BEQ: begin
                     taken_in  = (cmp == opa);
                     target_in = imm;
                  end
                  pxa_pkg::OP_BNE: begin
                     taken_in  = (cmp != opa);
                     target_in = imm;
                  end
                  pxa_pkg::OP_BGT: begin
                     taken_in  = $signed(opa) < $signed(cmp);
                     target_in = imm;
                  end
                  pxa_pkg::OP_BLT: begin
                     taken_in  = $signed(cmp) < $signed(opa);
                     target_in = imm;
                  end
                  pxa_pkg::OP_J:    target_in = in_ff.jump_target;
                  default: ;
               endcase
            end
            stalled_in = in_ff.memory_blocked;
            handoff_in = in_ff.memory_blocked ? pxa_pkg::HANDOFF_NONE
                                              : pxa_pkg::HANDOFF_RESULT;
         end else begin
            handoff_in = in_ff.memory_blocked ? pxa_pkg::HANDOFF_NONE
                                              : pxa_pkg::HANDOFF_BUBBLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff      <= '0;
         dest_ff    <= '0;
         value_ff   <= '0;
         store_ff   <= '0;
         taken_ff   <= 1'b0;
         target_ff  <= '0;
         stalled_ff <= 1'b0;
         handoff_ff <= pxa_pkg::HANDOFF_NONE;
      end else begin
         op_ff      <= op_in;
         dest_ff    <= dest_in;
         value_ff   <= value_in;
         store_ff   <= store_in;
         taken_ff   <= taken_in;
         target_ff  <= target_in;
         stalled_ff <= stalled_in;
         handoff_ff <= handoff_in;
      end
   end

   // response view of the held state
   always_comb begin
      rsp.pad               = '0;
      rsp.stage_blocked     = stalled_ff;
      rsp.target_address    = target_ff;
      rsp.taken_flag        = taken_ff;
      rsp.store_data        = store_ff;
      rsp.result_value      = value_ff;
      rsp.out_dest_register = dest_ff;
      rsp.out_op_code       = op_ff;
   end

   assign rsp_tdata = rsp;
   assign rsp_tuser = handoff_ff;

endmodule

`default_nettype wire

// File: design/pxa_ctrl.sv
// ----------------------------------------------------------------------------
// pxa_ctrl: sequencer of the execute ALU stage
// Accepts one transaction, runs the divider if needed, commits, then offers
// the result until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pxa_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   output pxa_pkg::cmd_type          cmd,
   input  wire pxa_pkg::status_type  status
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.commit = 1'b1;
               state_in   = ST_OUT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.commit = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: design/pipeline_execute_alu_stage.sv
// ----------------------------------------------------------------------------
// pipeline_execute_alu_stage: execute stage with a one-entry result register
// Each request transaction is one tick of the stage: a bubble or a decoded
// instruction plus the memory-stage block flag. Each produces one response.
//
// Channels: req_* carries the tick (tuser = has_instruction), rsp_* the
// handoff code (tuser) and the held result state (tdata). No configuration.
// Sequence: a non-dividing transaction is accepted in the idle state,
// committed in the evaluate state and offered in the output state; div
// and divi start the restoring divider in the evaluate state, run its 32
// steps in the divide state and commit in the finish state. Only one
// transaction is in flight; the next request is accepted the cycle after
// the response is taken.
// Reset clears the held result, the stall flag and the sequencer; req_tready
// is high in the first cycle after reset.
// While the receiver holds rsp_tready low the response stays stable and no
// new request is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pipeline_execute_alu_stage (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   // op_code, dest_register, operand_a, operand_b, shift_amount, immediate,
   // store_or_compare, jump_target, memory_blocked, zero fill
   input  wire [pxa_pkg::REQ_W-1:0]    req_tdata,
   // has_instruction
   input  wire                         req_tuser,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   // out_op_code, out_dest_register, result_value, store_data,
   // taken_flag, target_address, stage_blocked, zero fill
   output logic [pxa_pkg::RSP_W-1:0]   rsp_tdata,
   // handoff
   output logic [1:0]                  rsp_tuser
);

   pxa_pkg::cmd_type    cmd;
   pxa_pkg::status_type status;

   pxa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   pxa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: design/pxa_checker.sv
// ----------------------------------------------------------------------------
// pxa_checker: port-level checks of the execute ALU stage
// Bound to the top level; watches the request and response channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pxa_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_tvalid,
   input wire                       req_tready,
   input wire                       rsp_tvalid,
   input wire                       rsp_tready,
   input wire [pxa_pkg::RSP_W-1:0]  rsp_tdata,
   input wire [1:0]                 rsp_tuser
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // only one transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a response is pending");

   // no response in the cycle straight after acceptance
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("response without execute cycle");

   // handoff code is one of the defined ones
   a_handoff_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == pxa_pkg::HANDOFF_NONE
                  || rsp_tuser == pxa_pkg::HANDOFF_BUBBLE
                  || rsp_tuser == pxa_pkg::HANDOFF_RESULT)
      else $error("undefined handoff code");

   // a result handed on leaves the stage unblocked
   a_result_clears_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == pxa_pkg::HANDOFF_RESULT |-> !rsp_tdata[108])
      else $error("blocked after handing on a result");

endmodule

bind pipeline_execute_alu_stage pxa_checker u_pxa_checker (.*);

`default_nettype wire
